// ----- hdl/isa_pkg.sv -----
// Shared types and constants of the interleaved sector allocator.
// Holds request codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package isa_pkg;

  localparam int SECT_W     = 8;
  localparam int GRP_W      = 16;
  localparam int GRP_SHIFT  = 4;
  localparam int START_RESET = 245;

  localparam logic [7:0] OWNER_FREE    = 8'hFD;
  localparam logic [7:0] OWNER_MAP     = 8'hF8;
  localparam logic [7:0] OWNER_DAMAGED = 8'hFF;

  localparam logic [7:0] START_SECTOR_RST   = 8'd245;
  localparam logic [7:0] INTERLEAVE_GAP_RST = 8'd13;

  // Register index as taken from paddr[2].
  localparam logic REG_IDX_START = 1'b0;
  localparam logic REG_IDX_GAP   = 1'b1;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SRCH1,
    ST_WRITE,
    ST_SRCH2,
    ST_READ,
    ST_FINISH
  } state_e;

  typedef enum logic {
    SRC_CURSOR,
    SRC_GAP
  } srch_src_e;

  typedef struct packed {
    logic      latch;
    logic      clear_map;
    logic      srch_load;
    srch_src_e srch_sel;
    logic      srch_step;
    logic      commit;
    logic      set_cursor;
    logic      set_full;
    logic      rd_issue;
    logic      out_load;
  } isa_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic srch_hit;
  } isa_sts_t;

endpackage

// ----- hdl/isa_if.sv -----
// Valid/ready channel interfaces of the sector allocator: request and response.
// No dependencies.
`timescale 1ns / 1ps

interface isa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] stream_number;
  logic [7:0] block_index;
  logic [7:0] sector_index;

  modport source (output valid, req_type, stream_number, block_index, sector_index,
                  input ready);
  modport sink   (input valid, req_type, stream_number, block_index, sector_index,
                  output ready);
endinterface

interface isa_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] sector;
  logic [7:0] owner_code;
  logic [7:0] block_number;
  logic [7:0] cursor;

  modport source (output valid, status, sector, owner_code, block_number, cursor,
                  input ready);
  modport sink   (input valid, status, sector, owner_code, block_number, cursor,
                  output ready);
endinterface

// ----- hdl/isa_ctrl.sv -----
// Controller state machine of the sector allocator.
// Depends on isa_pkg; drives the datapath through isa_cmd_t.
`timescale 1ns / 1ps

module isa_ctrl import isa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic [1:0] req_type_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  input  isa_sts_t   sts_i,
  output isa_cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          case (req_e'(req_type_i))
            REQ_START: state_d = ST_START;
            REQ_ALLOC: begin
              cmd_o.srch_load = 1'b1;
              cmd_o.srch_sel  = SRC_CURSOR;
              state_d         = ST_SRCH1;
            end
            REQ_READ:  state_d = ST_READ;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_START: begin
        cmd_o.clear_map = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_SRCH1: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) begin
          if (sts_i.srch_hit) begin
            state_d = ST_WRITE;
          end else begin
            cmd_o.set_full = 1'b1;
            state_d        = ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.commit    = 1'b1;
        cmd_o.srch_load = 1'b1;
        cmd_o.srch_sel  = SRC_GAP;
        state_d         = ST_SRCH2;
      end
      ST_SRCH2: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) begin
          cmd_o.set_cursor = sts_i.srch_hit;
          cmd_o.set_full   = !sts_i.srch_hit;
          state_d          = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result register overwritten while held");

  // A new request is taken only with no item in flight.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> (state_q != ST_IDLE))
    else $error("accepted request did not leave idle");

  // A waiting response stays offered until the receiver takes it.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_ready_i) |=> rsp_valid_q)
    else $error("response dropped before it was taken");

endmodule

// ----- hdl/isa_dpath.sv -----
// Datapath of the sector allocator: sector map memory, written flags, cursor,
// grouped free-sector search and result register. Depends on isa_pkg.
`timescale 1ns / 1ps

module isa_dpath import isa_pkg::*; #(
  parameter int SECTOR_COUNT = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  isa_cmd_t   cmd_i,
  output isa_sts_t   sts_o,
  input  logic [1:0] req_type_i,
  input  logic [6:0] stream_number_i,
  input  logic [7:0] block_index_i,
  input  logic [7:0] sector_index_i,
  input  logic [7:0] start_sector_i,
  input  logic [7:0] interleave_gap_i,
  output logic       status_o,
  output logic [7:0] sector_o,
  output logic [7:0] owner_code_o,
  output logic [7:0] block_number_o,
  output logic [7:0] cursor_o
);

  localparam int AW     = $clog2(SECTOR_COUNT);
  localparam int NG     = (SECTOR_COUNT + GRP_W - 1) / GRP_W;
  localparam int GW     = $clog2(NG);
  localparam int CW     = $clog2(NG + 1);
  localparam int FLAT_W = NG * GRP_W;
  localparam logic [7:0] CURSOR_RST =
    8'((START_RESET < SECTOR_COUNT) ? START_RESET : SECTOR_COUNT - 1);
  localparam logic [8:0] SC9   = 9'(SECTOR_COUNT);
  localparam logic [7:0] LAST  = 8'(SECTOR_COUNT - 1);

  // Request fields of the item in flight.
  req_e       req_q;
  logic [6:0] stream_q;
  logic [7:0] block_q;
  logic [7:0] idx_q;

  logic [SECTOR_COUNT-1:0] written_q;
  logic [7:0]              cursor_q;
  logic                    full_q;
  logic                    granted_q;
  logic [7:0]              grant_q;
  logic [7:0]              hit_sec_q;

  logic [15:0] map_mem [SECTOR_COUNT];
  logic [15:0] rd_word_q;
  logic        rd_written_q;

  // Search state.
  logic [GW-1:0] srch_grp_q;
  logic [3:0]    srch_bit_q;
  logic          srch_first_q;
  logic [CW-1:0] srch_cnt_q;

  logic [FLAT_W-1:0] free_flat;
  logic [GRP_W-1:0]  grp_bits;
  logic [GRP_W-1:0]  grp_mask;
  logic [3:0]        hit_pos;
  logic              hit_any;
  logic [7:0]        found_sec;
  logic [7:0]        gap_mod_d;
  logic [7:0]        gap_mod_q;
  logic [7:0]        next_from;
  logic [7:0]        srch_from;

  for (genvar i = 0; i < FLAT_W; i++) begin : g_free
    if (i > 0 && i < SECTOR_COUNT - 1) begin : g_real
      assign free_flat[i] = !written_q[i];
    end else begin : g_fixed
      assign free_flat[i] = 1'b0;
    end
  end

  // One group of sixteen sectors is examined per step, highest sector first.
  always_comb begin
    grp_bits = free_flat[{srch_grp_q, 4'b0000} +: GRP_W];
    grp_mask = srch_first_q ? (16'hFFFF >> (4'd15 - srch_bit_q)) : 16'hFFFF;
    hit_pos  = 4'd0;
    for (int i = 0; i < GRP_W; i++) begin
      if (grp_bits[i] && grp_mask[i]) begin
        hit_pos = 4'(i);
      end
    end
    hit_any   = |(grp_bits & grp_mask);
    found_sec = (8'(srch_grp_q) << GRP_SHIFT) | 8'(hit_pos);
  end

  assign sts_o.srch_hit  = hit_any;
  assign sts_o.srch_done = hit_any || (srch_cnt_q == CW'(NG));

  // Gap reduced modulo the sector count by restoring subtraction, registered.
  // The user must change the gap only while idle; the block does not check.
  always_comb begin
    logic [15:0] r;
    r = {8'h00, interleave_gap_i};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(SECTOR_COUNT) << k)) begin
        r = r - (16'(SECTOR_COUNT) << k);
      end
    end
    gap_mod_d = r[7:0];
  end

  always_comb begin
    logic [8:0] sum;
    sum = {1'b0, hit_sec_q} + SC9 - {1'b0, gap_mod_q};
    if (sum >= SC9) begin
      sum = sum - SC9;
    end
    next_from = sum[7:0];
  end

  assign srch_from = (cmd_i.srch_sel == SRC_GAP) ? next_from : cursor_q;

  always_ff @(posedge clk_i) begin
    gap_mod_q <= gap_mod_d;
    if (cmd_i.srch_load) begin
      srch_grp_q   <= srch_from[GRP_SHIFT +: GW];
      srch_bit_q   <= srch_from[3:0];
      srch_first_q <= 1'b1;
      srch_cnt_q   <= '0;
    end else if (cmd_i.srch_step) begin
      srch_grp_q   <= (srch_grp_q == '0) ? GW'(NG - 1) : srch_grp_q - 1'b1;
      srch_first_q <= 1'b0;
      srch_cnt_q   <= srch_cnt_q + 1'b1;
    end
    if (cmd_i.srch_step && hit_any) begin
      hit_sec_q <= found_sec;
    end
    if (cmd_i.latch) begin
      req_q    <= req_e'(req_type_i);
      stream_q <= stream_number_i;
      block_q  <= block_index_i;
      idx_q    <= sector_index_i;
    end
    if (cmd_i.commit) begin
      grant_q <= hit_sec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      cursor_q  <= CURSOR_RST;
      full_q    <= 1'b0;
      granted_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        full_q    <= 1'b0;
        granted_q <= 1'b0;
      end
      if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        granted_q                   <= 1'b1;
        written_q[hit_sec_q[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.clear_map) begin
        written_q <= '0;
        cursor_q  <= ({1'b0, start_sector_i} >= SC9) ? LAST : start_sector_i;
      end else if (cmd_i.set_cursor) begin
        cursor_q <= found_sec;
      end
    end
  end

  // Map memory: owner in the upper byte, block number in the lower byte.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      map_mem[hit_sec_q[AW-1:0]] <= {1'b0, stream_q, block_q};
    end
    if (cmd_i.rd_issue) begin
      rd_word_q    <= map_mem[idx_q[AW-1:0]];
      rd_written_q <= written_q[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o       <= full_q;
      cursor_o       <= cursor_q;
      sector_o       <= 8'h00;
      owner_code_o   <= 8'h00;
      block_number_o <= 8'h00;
      case (req_q)
        REQ_ALLOC: begin
          if (granted_q) begin
            sector_o       <= grant_q;
            owner_code_o   <= {1'b0, stream_q};
            block_number_o <= block_q;
          end
        end
        REQ_READ: begin
          sector_o <= idx_q;
          if ({1'b0, idx_q} >= SC9) begin
            owner_code_o <= OWNER_DAMAGED;
          end else if (rd_written_q) begin
            owner_code_o   <= rd_word_q[15:8];
            block_number_o <= rd_word_q[7:0];
          end else if (idx_q == 8'h00) begin
            owner_code_o <= OWNER_MAP;
          end else if (idx_q == LAST) begin
            owner_code_o <= OWNER_DAMAGED;
          end else begin
            owner_code_o <= OWNER_FREE;
          end
        end
        default: ;
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cursor_q} < SC9)
    else $error("cursor outside medium");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.srch_step && hit_any) |-> ({1'b0, found_sec} < SC9))
    else $error("search found sector outside medium");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> free_flat[hit_sec_q[GW+3:0]])
    else $error("block recorded on a sector that is not free");

endmodule

// ----- hdl/interleaved_sector_allocator_core.sv -----
// Top level of the interleaved sector allocator.
// Depends on isa_pkg, isa_if (isa_req_if, isa_rsp_if), isa_ctrl and isa_dpath.
`timescale 1ns / 1ps

// The block keeps the sector map of a tape medium and hands out sectors.
// Requests arrive as beats on req_i (start new map, allocate one block, read
// one map entry); every request gives exactly one response beat on rsp_o,
// in order. The user writes start_sector and interleave_gap over the APB port,
// at byte addresses 0 and 4, only while the block is idle; it is not enforced.
//
// One request is worked on at a time. A start or a read passes from the
// accepting state through its working state (ST_START or ST_READ) to the
// finishing state, where its response beat is loaded into the output register.
// An allocate runs two free-sector searches, each examining one group of 16
// sectors per cycle and ending at the first free sector or once it has come
// round all NG groups (NG = SECTOR_COUNT/16 rounded up); the accept, the commit
// between the searches and the result load come on top. The search loop over
// groups sets how long an allocate holds the block.
//
// After reset the map reads as empty at once: a written flag per sector marks
// entries that hold data, so no clearing pass runs. A start request clears the
// flags all at once. The response sits in an output register; while the
// receiver stalls it holds, and the block still accepts the next request and
// works it up to the point where its result would be loaded.

module interleaved_sector_allocator_core import isa_pkg::*; #(
  parameter int SECTOR_COUNT = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  isa_req_if.sink      req_i,
  isa_rsp_if.source    rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  isa_cmd_t cmd;
  isa_sts_t sts;

  logic [7:0] start_sector_q;
  logic [7:0] interleave_gap_q;
  logic       cfg_wr;

  // Configuration registers; the write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_sector_q   <= START_SECTOR_RST;
      interleave_gap_q <= INTERLEAVE_GAP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDX_START) begin
        start_sector_q <= pwdata[7:0];
      end else begin
        interleave_gap_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_IDX_START) ? {24'h000000, start_sector_q}
                                              : {24'h000000, interleave_gap_q};

  isa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  isa_dpath #(
    .SECTOR_COUNT (SECTOR_COUNT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .stream_number_i  (req_i.stream_number),
    .block_index_i    (req_i.block_index),
    .sector_index_i   (req_i.sector_index),
    .start_sector_i   (start_sector_q),
    .interleave_gap_i (interleave_gap_q),
    .status_o         (rsp_o.status),
    .sector_o         (rsp_o.sector),
    .owner_code_o     (rsp_o.owner_code),
    .block_number_o   (rsp_o.block_number),
    .cursor_o         (rsp_o.cursor)
  );

endmodule

// ----- test/interleaved_sector_allocator_core_tb.sv -----
// Self-checking testbench of interleaved_sector_allocator_core.
// Drives request beats and APB register writes, predicts every response beat in
// SV and compares field by field. Depends on isa_pkg and isa_if from hdl.
`timescale 1ns / 1ps

module interleaved_sector_allocator_core_tb;
  import isa_pkg::*;

  localparam int SECTORS = 255;

  // Byte addresses of the two configuration registers.
  localparam logic [2:0] ADDR_START = {REG_IDX_START, 2'b00};
  localparam logic [2:0] ADDR_GAP   = {REG_IDX_GAP, 2'b00};

  // Idling per random phase: none, sender only, receiver only, both.
  localparam int SRC_IDLE_PCT[4]   = '{0, 58, 0, 20};
  localparam int SINK_STALL_PCT[4] = '{0, 0, 58, 20};

  typedef struct packed {
    logic       status;
    logic [7:0] sector;
    logic [7:0] owner_code;
    logic [7:0] block_number;
    logic [7:0] cursor;
  } sector_rsp_t;

  // One row of stimulus. set_cfg writes both registers (while idle) before the
  // request goes out; pinned rows carry a response typed in by hand.
  typedef struct packed {
    logic        set_cfg;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_gap;
    req_e        kind;
    logic [6:0]  stream;
    logic [7:0]  block;
    logic [7:0]  index;
    logic        pinned;
    sector_rsp_t rsp;
  } map_req_t;

  // Directed part. After reset the cursor is 245, the gap 13 and the map empty.
  localparam map_req_t DIRECTED_ROWS [20] = '{
    // map sector, damaged last sector, read beyond the medium, a free sector
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd0, 1'b1,
      '{1'b0, 8'd0, OWNER_MAP, 8'd0, 8'd245}},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd254, 1'b1,
      '{1'b0, 8'd254, OWNER_DAMAGED, 8'd0, 8'd245}},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd255, 1'b1,
      '{1'b0, 8'd255, OWNER_DAMAGED, 8'd0, 8'd245}},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd100, 1'b1,
      '{1'b0, 8'd100, OWNER_FREE, 8'd0, 8'd245}},
    // first blocks land on the cursor, then 13 sectors further down
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'd0, 8'd0, 8'd0, 1'b1,
      '{1'b0, 8'd245, 8'd0, 8'd0, 8'd232}},
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'd126, 8'd255, 8'd0, 1'b1,
      '{1'b0, 8'd232, 8'd126, 8'd255, 8'd219}},
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'd127, 8'h55, 8'hff, 1'b0, '0},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'h7f, 8'hff, 8'd245, 1'b0, '0},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd232, 1'b0, '0},
    '{1'b0, 8'd0, 8'd0, REQ_NONE, 7'h2a, 8'haa, 8'h55, 1'b0, '0},
    // a new map forgets the allocations and reloads the cursor
    '{1'b0, 8'd0, 8'd0, REQ_START, 7'h55, 8'h33, 8'hcc, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'd0, 8'd245}},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd232, 1'b0, '0},
    // start sector beyond the medium saturates; a zero gap retries below
    '{1'b1, 8'd255, 8'd0, REQ_START, 7'd0, 8'd0, 8'd0, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'd0, 8'd254}},
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'd5, 8'd7, 8'd0, 1'b1,
      '{1'b0, 8'd253, 8'd5, 8'd7, 8'd252}},
    // cursor 0 wraps past the map and damaged sectors; gap 255 acts as 0
    '{1'b1, 8'd0, 8'd255, REQ_START, 7'd0, 8'd0, 8'd0, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'd127, 8'd0, 8'd0, 1'b1,
      '{1'b0, 8'd253, 8'd127, 8'd0, 8'd252}},
    '{1'b0, 8'd0, 8'd0, REQ_READ, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    // largest legal start and gap
    '{1'b1, 8'd254, 8'd254, REQ_START, 7'd0, 8'd0, 8'd0, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'd0, 8'd254}},
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'd1, 8'd1, 8'd0, 1'b0, '0},
    '{1'b0, 8'd0, 8'd0, REQ_ALLOC, 7'h40, 8'h80, 8'd253, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  isa_req_if req_bus ();
  isa_rsp_if rsp_bus ();

  interleaved_sector_allocator_core #(
    .SECTOR_COUNT(SECTORS)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: map, cursor and registers.
  logic [7:0] map_owner [SECTORS];
  logic [7:0] map_blkno [SECTORS];
  logic [7:0] alloc_cur;
  logic [7:0] cfg_start;
  logic [7:0] cfg_gap;

  sector_rsp_t pending_rsp [$];
  logic        pin_active = 1'b0;
  sector_rsp_t pin_rsp = '0;
  int          fail_count = 0;
  int          sent_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  function automatic void clear_sector_map();
    for (int i = 0; i < SECTORS; i++) begin
      map_owner[i] = OWNER_FREE;
      map_blkno[i] = 8'd0;
    end
    map_owner[0] = OWNER_MAP;
    map_owner[SECTORS-1] = OWNER_DAMAGED;
    alloc_cur = (cfg_start >= SECTORS) ? 8'(SECTORS - 1) : cfg_start;
  endfunction

  // Downward search for a free sector with wrap; -1 when the medium is full.
  function automatic int next_free_sector(input int from);
    int cand;
    cand = from % SECTORS;
    for (int n = 0; n < SECTORS; n++) begin
      if (map_owner[cand] == OWNER_FREE) return cand;
      cand = (cand == 0) ? SECTORS - 1 : cand - 1;
    end
    return -1;
  endfunction

  function automatic sector_rsp_t predict_request(input req_e kind, input logic [6:0] stream,
                                                  input logic [7:0] blk,
                                                  input logic [7:0] idx);
    sector_rsp_t r;
    int s;
    int nxt;
    int gap;
    r = '0;
    case (kind)
      REQ_START: begin
        clear_sector_map();
      end
      REQ_ALLOC: begin
        s = next_free_sector(int'(alloc_cur));
        if (s < 0) begin
          r.status = 1'b1;
        end else begin
          gap = int'(cfg_gap) % SECTORS;
          map_owner[s] = {1'b0, stream};
          map_blkno[s] = blk;
          r.sector = 8'(s);
          r.owner_code = {1'b0, stream};
          r.block_number = blk;
          // The block stays recorded even when no sector is left for the cursor.
          nxt = next_free_sector((s + SECTORS - gap) % SECTORS);
          if (nxt < 0) r.status = 1'b1;
          else alloc_cur = 8'(nxt);
        end
      end
      REQ_READ: begin
        r.sector = idx;
        if (idx < SECTORS) begin
          r.owner_code = map_owner[idx];
          r.block_number = map_blkno[idx];
        end else begin
          r.owner_code = OWNER_DAMAGED;
        end
      end
      default: begin
      end
    endcase
    r.cursor = alloc_cur;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Receiver: ready is redrawn every cycle from the stall rate of the phase.
  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Response beats are checked before the request beat of the same edge is
  // predicted, so a stray response can never consume a fresh expectation.
  always @(posedge clk) begin
    sector_rsp_t got;
    sector_rsp_t want;
    if (rsp_bus.valid && rsp_bus.ready) begin
      got = '{rsp_bus.status, rsp_bus.sector, rsp_bus.owner_code, rsp_bus.block_number,
              rsp_bus.cursor};
      if (pending_rsp.size() == 0) begin
        $display("%0t: response beat with nothing expected, got %0h", $time, got);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", {7'd0, want.status}, {7'd0, got.status});
        check_field("sector", want.sector, got.sector);
        check_field("owner_code", want.owner_code, got.owner_code);
        check_field("block_number", want.block_number, got.block_number);
        check_field("cursor", want.cursor, got.cursor);
      end
    end
    if (req_bus.valid && req_bus.ready) begin
      want = predict_request(req_e'(req_bus.req_type), req_bus.stream_number,
                             req_bus.block_index, req_bus.sector_index);
      pending_rsp.push_back(pin_active ? pin_rsp : want);
    end
  end

  // Offers one request beat after a random number of idle cycles and returns
  // at the edge where it is taken.
  task automatic send_item(input map_req_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= item.kind;
    req_bus.stream_number <= item.stream;
    req_bus.block_index <= item.block;
    req_bus.sector_index <= item.index;
    pin_active <= item.pinned;
    pin_rsp <= item.rsp;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sent_count++;
  endtask

  // Lets every outstanding response come back, then gives the block time to
  // settle before registers change or the run ends.
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // The bus is released before the task returns, so a following write starts
  // with its own setup cycle.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_map(input logic [7:0] start, input logic [7:0] gap);
    wait_idle();
    apb_write(ADDR_START, {24'd0, start});
    cfg_start = start;
    apb_write(ADDR_GAP, {24'd0, gap});
    cfg_gap = gap;
  endtask

  // A session opens a new map and then mostly allocates, with reads and
  // unused request codes mixed in. A fill session runs the medium full, so
  // that both the cursor search and then the block search come up empty.
  task automatic random_session(input bit fill);
    map_req_t item;
    int steps;
    int r;
    item = '0;
    item.kind = REQ_START;
    item.stream = 7'($urandom_range(0, 127));
    item.block = 8'($urandom_range(0, 255));
    item.index = 8'($urandom_range(0, 255));
    send_item(item);
    steps = fill ? 320 : $urandom_range(1, 40);
    repeat (steps) begin
      r = $urandom_range(99);
      item.stream = 7'($urandom_range(0, 127));
      item.block = 8'($urandom_range(0, 255));
      item.index = 8'($urandom_range(0, 255));
      if (r < (fill ? 88 : 68)) item.kind = REQ_ALLOC;
      else if (r < (fill ? 96 : 88)) item.kind = REQ_READ;
      else if (fill || r < 95) item.kind = REQ_NONE;
      else item.kind = REQ_START;
      send_item(item);
    end
  endtask

  initial begin
    int phase_base;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_NONE;
    req_bus.stream_number = '0;
    req_bus.block_index = '0;
    req_bus.sector_index = '0;
    rsp_bus.ready = 1'b0;
    cfg_start = START_SECTOR_RST;
    cfg_gap = INTERLEAVE_GAP_RST;
    clear_sector_map();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 20;
    sink_stall_pct = 20;
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].set_cfg) program_map(DIRECTED_ROWS[i].cfg_start,
                                                DIRECTED_ROWS[i].cfg_gap);
      send_item(DIRECTED_ROWS[i]);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: program_map(8'd200, 8'd1);
        3: program_map(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: program_map(8'($urandom_range(0, 254)), 8'($urandom_range(1, 254)));
      endcase
      src_idle_pct = SRC_IDLE_PCT[p];
      sink_stall_pct = SINK_STALL_PCT[p];
      phase_base = sent_count;
      if (p == 0) random_session(1'b1);
      while (sent_count - phase_base < 80) random_session(1'b0);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout, %0d responses still expected", $time, pending_rsp.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
